### rtl/utc_pkg.sv
// utc_pkg: types, register codes and calendar helpers for the date to timestamp block
// no dependencies; used by the interfaces and by every rtl module but utc_checker

package utc_pkg;

  localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
  localparam int          QUEUE_DEPTH   = 2;
  localparam int          CFG_INDEX_W   = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_YEAR      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_SECONDS = 4'd1;

  localparam logic [11:0] BASE_YEAR_RESET      = 12'd2000;
  localparam logic [31:0] OFFSET_SECONDS_RESET = 32'd0;

  typedef struct packed {
    logic [11:0] base_year;
    logic [31:0] offset_seconds;
  } cfg_regs_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic        valid_res;
    logic [7:0]  year_offset;
    logic [12:0] year;
    logic [8:0]  month_days;   // days before the month, leap day included
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cls_t;

  // floor(x / 25) for x below 2048, reciprocal multiply
  function automatic logic [6:0] div25(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd1311;
    return p[21:15];
  endfunction

  // leap years in [0, y)
  function automatic logic [11:0] leaps_below(input logic [12:0] y);
    logic [13:0] a;
    logic [13:0] b;
    logic [13:0] c;
    logic [11:0] q4;
    logic [6:0]  q100;
    logic [6:0]  q400;
    a    = {1'b0, y} + 14'd3;
    b    = {1'b0, y} + 14'd99;
    c    = {1'b0, y} + 14'd399;
    q4   = a[13:2];
    q100 = div25(b[12:2]);
    q400 = div25({2'b00, c[12:4]});
    return q4 - {5'd0, q100} + {5'd0, q400};
  endfunction

  function automatic logic is_leap(input logic [12:0] y);
    logic [6:0]  q100;
    logic [6:0]  q400;
    logic [13:0] m100;
    logic [15:0] m400;
    q100 = div25(y[12:2]);
    q400 = div25({2'b00, y[12:4]});
    m100 = 14'({7'd0, q100} * 14'd100);
    m400 = 16'({9'd0, q400} * 16'd400);
    return ({3'd0, y} == m400) || ((y[1:0] == 2'b00) && ({1'b0, y} != m100));
  endfunction

  // days in the common year before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

### rtl/utc_ifs.sv
// utc_ifs: valid/ready channel interfaces for dates, results and configuration writes
// depends on utc_pkg for the configuration index width

interface utc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_offset;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  modport source(output valid, year_offset, month, day, hour, minute, second, input ready);
  modport sink(input valid, year_offset, month, day, hour, minute, second, output ready);
endinterface

interface utc_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [32:0] epoch_seconds;
  logic [63:0] timestamp_ns;
  modport source(output valid, valid_res, epoch_seconds, timestamp_ns, input ready);
  modport sink(input valid, valid_res, epoch_seconds, timestamp_ns, output ready);
endinterface

interface utc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [utc_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/utc_front.sv
// utc_front: range check and calendar classification of one date per cycle
// depends on utc_pkg (cls_t, leap test, month table)

module utc_front (
  input  logic [7:0]         year_offset,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  utc_pkg::cfg_regs_t cfg_regs,
  output utc_pkg::cls_t      cls
);
  import utc_pkg::*;

  logic [12:0] year;
  logic        leap;
  logic        in_range;

  always_comb begin
    year     = {1'b0, cfg_regs.base_year} + {5'd0, year_offset};
    leap     = is_leap(year);
    in_range = (month inside {[4'd1:4'd12]}) && (day != 5'd0) && (hour < 5'd24) &&
               (minute < 6'd60) && (second < 6'd60);
    cls.valid_res   = in_range;
    cls.year_offset = year_offset;
    cls.year        = year;
    cls.month_days  = days_before(month) + {8'd0, leap && (month > 4'd2)};
    cls.day         = day;
    cls.hour        = hour;
    cls.minute      = minute;
    cls.second      = second;
  end

endmodule

### rtl/utc_queue.sv
// utc_queue: short register queue of classified items between front and back
// depends on utc_pkg (cls_t, QUEUE_DEPTH)

module utc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  utc_pkg::cls_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output utc_pkg::cls_t rd_data
);
  import utc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cls_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

### rtl/utc_back.sv
// utc_back: multi-cycle sequencer turning a classified date into seconds and nanoseconds
// depends on utc_pkg (cls_t, cfg_regs_t, leaps_below, NS_PER_SECOND)

module utc_back (
  input  logic               clk,
  input  logic               rst,
  input  utc_pkg::cfg_regs_t cfg_regs,
  input  logic               rd_valid,
  output logic               rd_ready,
  input  utc_pkg::cls_t      rd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [32:0]        out_epoch_seconds,
  output logic [63:0]        out_timestamp_ns
);
  import utc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEAP, ST_DAYS, ST_HOURS, ST_MINS, ST_SECS, ST_SUM, ST_MLO, ST_MHI, ST_DONE
  } state_t;

  state_t      state;
  cls_t        item;
  logic [11:0] lb_year;
  logic [16:0] days;
  logic [32:0] acc;
  logic [33:0] sum;
  logic [63:0] prod;

  logic [17:0] days_next;
  logic [21:0] hours_next;
  logic [27:0] mins_next;
  logic [32:0] secs_next;
  logic [46:0] part_lo;
  logic [46:0] part_hi;
  logic        out_free;

  assign rd_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    days_next  = 18'({10'd0, item.year_offset} * 18'd365) + {6'd0, lb_year}
                 - {6'd0, leaps_below({1'b0, cfg_regs.base_year})}
                 + {9'd0, item.month_days} + {13'd0, item.day} - 18'd1;
    hours_next = 22'({5'd0, days} * 22'd24) + {17'd0, item.hour};
    mins_next  = 28'({6'd0, acc[21:0]} * 28'd60) + {22'd0, item.minute};
    secs_next  = 33'({5'd0, acc[27:0]} * 33'd60) + {27'd0, item.second};
    part_lo    = {30'd0, sum[16:0]} * NS_PER_SECOND[46:0];
    part_hi    = {30'd0, sum[33:17]} * NS_PER_SECOND[46:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rd_valid) begin
            item  <= rd_data;
            acc   <= '0;
            prod  <= '0;
            state <= rd_data.valid_res ? ST_LEAP : ST_DONE;
          end
        end
        ST_LEAP: begin
          lb_year <= leaps_below(item.year);
          state   <= ST_DAYS;
        end
        ST_DAYS: begin
          days  <= days_next[16:0];
          state <= ST_HOURS;
        end
        ST_HOURS: begin
          acc   <= {11'd0, hours_next};
          state <= ST_MINS;
        end
        ST_MINS: begin
          acc   <= {5'd0, mins_next};
          state <= ST_SECS;
        end
        ST_SECS: begin
          acc   <= secs_next;
          state <= ST_SUM;
        end
        ST_SUM: begin
          sum   <= {2'd0, cfg_regs.offset_seconds} + {1'b0, acc};
          state <= ST_MLO;
        end
        ST_MLO: begin
          prod  <= {17'd0, part_lo};
          state <= ST_MHI;
        end
        ST_MHI: begin
          prod  <= prod + {part_hi, 17'd0};
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_res     <= item.valid_res;
            out_epoch_seconds <= acc;
            out_timestamp_ns  <= prod;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/utc_date_to_timestamp.sv
// utc_date_to_timestamp: top level, configuration registers, front, queue and back
// depends on utc_pkg, utc_ifs, utc_front, utc_queue, utc_back
//
//   channel  dir  handshake      payload
//   dates    in   valid/ready    year_offset month day hour minute second
//   stamps   out  valid/ready    valid_res epoch_seconds timestamp_ns
//   cfg      in   valid/ready    index data (0 base_year, 1 offset_seconds)
//
// a date goes from queue head to result register through the back sequencer steps
// in order (leap count, day sum, three scaling steps, offset add, two partial
// products); an out-of-range date skips these steps and goes straight to done
// the front classifies in the transfer cycle and the queue holds two dates
// rst is synchronous: queue, sequencer and output valid clear, registers reload
// a stalled result holds in its register while the next date is worked on

module utc_date_to_timestamp (
  input  logic             clk,
  input  logic             rst,
  utc_in_if.sink           dates,
  utc_out_if.source        stamps,
  utc_cfg_if.sink          cfg
);
  import utc_pkg::*;

  cfg_regs_t cfg_regs;
  cls_t      front_cls;
  cls_t      queue_head;
  logic      queue_valid;
  logic      queue_ready;

  // configuration writes are always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.base_year      <= BASE_YEAR_RESET;
      cfg_regs.offset_seconds <= OFFSET_SECONDS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BASE_YEAR:      cfg_regs.base_year      <= cfg.data[11:0];
        CFG_OFFSET_SECONDS: cfg_regs.offset_seconds <= cfg.data;
        default: begin
          // unknown register index, write dropped
        end
      endcase
    end
  end

  // front: range check, year, leap day and month offset
  utc_front u_front (
    .year_offset (dates.year_offset),
    .month       (dates.month),
    .day         (dates.day),
    .hour        (dates.hour),
    .minute      (dates.minute),
    .second      (dates.second),
    .cfg_regs    (cfg_regs),
    .cls         (front_cls)
  );

  // queue: a date transfer lands here, dates.ready follows queue space
  utc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (dates.valid),
    .wr_ready (dates.ready),
    .wr_data  (front_cls),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_head)
  );

  // back: seconds count and nanosecond scaling, ends in the result register
  utc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_regs          (cfg_regs),
    .rd_valid          (queue_valid),
    .rd_ready          (queue_ready),
    .rd_data           (queue_head),
    .out_valid         (stamps.valid),
    .out_ready         (stamps.ready),
    .out_valid_res     (stamps.valid_res),
    .out_epoch_seconds (stamps.epoch_seconds),
    .out_timestamp_ns  (stamps.timestamp_ns)
  );

endmodule

### rtl/utc_checker.sv
// utc_checker: port-level assertions on the result channel, bound to the top level
// depends on utc_date_to_timestamp and its interfaces through the bind

module utc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [32:0] epoch_seconds,
  input logic [63:0] timestamp_ns
);

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(epoch_seconds) &&
                                $stable(timestamp_ns) && $stable(valid_res))
    else $error("stalled result changed");

  // rejected dates carry zero payload
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> (epoch_seconds == 33'd0) && (timestamp_ns == 64'd0))
    else $error("rejected date with nonzero payload");

  // an offered result carries a fully known payload
  a_known_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({valid_res, epoch_seconds, timestamp_ns}))
    else $error("result payload has unknown bits");

endmodule

bind utc_date_to_timestamp utc_checker u_utc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (stamps.valid),
  .out_ready     (stamps.ready),
  .valid_res     (stamps.valid_res),
  .epoch_seconds (stamps.epoch_seconds),
  .timestamp_ns  (stamps.timestamp_ns)
);
